/* rtl/tmis_pkg.sv */
// Shared types, constants and command structs for the tape interpreter step unit.
package tmis_pkg;

	localparam int unsigned ProgramDepthDefault = 1024;
	localparam int unsigned TapeCellsDefault    = 128;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_STEP   = 2'd1;
	localparam logic [1:0] OP_REWIND = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] ST_READY    = 3'd0;
	localparam logic [2:0] ST_FINISHED = 3'd1;
	localparam logic [2:0] ST_DIVZERO  = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_UNMATCH  = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	localparam logic [7:0] CH_RIGHT   = 8'h3E;
	localparam logic [7:0] CH_RIGHT_N = 8'h6E;
	localparam logic [7:0] CH_LEFT    = 8'h3C;
	localparam logic [7:0] CH_LEFT_P  = 8'h70;
	localparam logic [7:0] CH_INC     = 8'h2B;
	localparam logic [7:0] CH_DEC     = 8'h2D;
	localparam logic [7:0] CH_OUT     = 8'h2E;
	localparam logic [7:0] CH_OUT_O   = 8'h6F;
	localparam logic [7:0] CH_IN      = 8'h2C;
	localparam logic [7:0] CH_IN_I    = 8'h69;
	localparam logic [7:0] CH_OPEN    = 8'h5B;
	localparam logic [7:0] CH_CLOSE   = 8'h5D;
	localparam logic [7:0] CH_CLOSE_Z = 8'h29;
	localparam logic [7:0] CH_MUL     = 8'h2A;
	localparam logic [7:0] CH_DIV     = 8'h2F;

	// datapath commands, one-hot-ish per cycle from controller
	typedef struct packed {
		logic load_in;     // capture input word
		logic append;      // write program char
		logic rewind;      // start tape clear
		logic clear_prog;
		logic fetch;       // read program at pc and tape at ptr
		logic exec;        // decode and apply instruction
		logic div_start;
		logic div_step;
		logic div_done;
		logic scan_start;
		logic scan_read;   // issue program read at scan index
		logic scan_eval;   // evaluate read character
		logic clr_step;
		logic result;      // capture result word
	} tmis_cmd_t;

	typedef struct packed {
		logic need_div;
		logic need_scan;
		logic div_last;
		logic scan_done;
		logic clr_last;
	} tmis_sts_t;

endpackage

/* rtl/tmis_if.sv */
// Valid/ready channel interfaces for input and result words.
interface tmis_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] character;
	logic [7:0] value;
	modport source (output valid, output operation, output character, output value, input ready);
	modport sink (input valid, input operation, input character, input value, output ready);
endinterface

interface tmis_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        output_valid;
	logic [7:0]  output_value;
	logic        input_used;
	logic [10:0] program_counter;
	logic [6:0]  cell_pointer;
	logic [7:0]  cell_value;
	modport source (output valid, output status, output output_valid, output output_value,
		output input_used, output program_counter, output cell_pointer, output cell_value,
		input ready);
	modport sink (input valid, input status, input output_valid, input output_value,
		input input_used, input program_counter, input cell_pointer, input cell_value,
		output ready);
endinterface

/* rtl/tmis_ctrl.sv */
// Controller state machine sequencing each word through the datapath.
module tmis_ctrl import tmis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_op,
	output logic       out_valid,
	input  logic       out_ready,
	input  tmis_sts_t  sts,
	output tmis_cmd_t  cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_FETCH = 10'b0000000010,
		S_EXEC  = 10'b0000000100,
		S_DIV   = 10'b0000001000,
		S_SREAD = 10'b0000010000,
		S_SEVAL = 10'b0000100000,
		S_CLR   = 10'b0001000000,
		S_RES   = 10'b0010000000,
		S_DIVF  = 10'b0100000000,
		S_INIT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	// next word enters only once the result slot is empty or being emptied
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_INIT: begin
				// tape clearing sweep after reset
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load_in = 1'b1;
					unique case (in_op)
						OP_APPEND: begin cmd.append = 1'b1; state_d = S_RES; end
						OP_STEP:   begin cmd.fetch = 1'b1; state_d = S_FETCH; end
						OP_REWIND: begin cmd.rewind = 1'b1; state_d = S_CLR; end
						OP_CLEAR:  begin cmd.clear_prog = 1'b1; state_d = S_RES; end
						default: state_d = S_RES;
					endcase
				end
			end
			S_FETCH: state_d = S_EXEC;
			S_EXEC: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else if (sts.need_scan) begin
					cmd.scan_start = 1'b1;
					state_d = S_SREAD;
				end else begin
					cmd.exec = 1'b1;
					state_d = S_RES;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_DIVF;
			end
			S_DIVF: begin
				cmd.div_done = 1'b1;
				state_d = S_RES;
			end
			S_SREAD: begin
				if (sts.scan_done) begin
					state_d = S_RES;
				end else begin
					cmd.scan_read = 1'b1;
					state_d = S_SEVAL;
				end
			end
			S_SEVAL: begin
				cmd.scan_eval = 1'b1;
				state_d = S_SREAD;
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_RES;
			end
			S_RES: begin
				cmd.result = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

/* rtl/tmis_dp.sv */
// Datapath: program store, tape, pointers, serial divider and bracket scan.
module tmis_dp import tmis_pkg::*; #(
	parameter int unsigned PROGRAM_DEPTH = ProgramDepthDefault,
	parameter int unsigned TAPE_CELLS    = TapeCellsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tmis_cmd_t   cmd,
	output tmis_sts_t   sts,
	input  logic [7:0]  in_character,
	input  logic [7:0]  in_value,
	output logic [2:0]  status,
	output logic        output_valid,
	output logic [7:0]  output_value,
	output logic        input_used,
	output logic [10:0] program_counter,
	output logic [6:0]  cell_pointer,
	output logic [7:0]  cell_value
);
	localparam int PW = $clog2(PROGRAM_DEPTH);
	localparam int LW = PW + 1;
	localparam int TW = $clog2(TAPE_CELLS);

	logic [7:0]    prog_mem [PROGRAM_DEPTH];
	logic [7:0]    tape_mem [TAPE_CELLS];

	logic [LW-1:0] plen_q, pc_q, scan_q;
	logic [LW-1:0] depth_q;
	logic [TW-1:0] ptr_q, clr_q;
	logic [2:0]    stop_q;
	logic [7:0]    val_q;
	logic          full_q, ovalid_q, iused_q;
	logic [7:0]    oval_q;
	logic [7:0]    instr_q, cell_q, nb_q;
	logic          scan_done_q;

	// divider state
	logic [7:0]    quo_q, rem_q;
	logic [2:0]    dcnt_q;

	logic [7:0]    trd_q;
	logic [7:0]    nb_c;

	logic          active;
	logic          ptr_last;
	assign active   = (stop_q == ST_READY) && (pc_q < plen_q);
	assign ptr_last = ({{(32-TW){1'b0}}, ptr_q} == TAPE_CELLS - 1);

	logic is_close, is_closez;
	assign is_close  = instr_q == CH_CLOSE;
	assign is_closez = instr_q == CH_CLOSE_Z;

	// neighbour read lands in trd_q for the exec cycle
	assign sts.need_div  = active && instr_q == CH_DIV && nb_c != 8'd0;
	assign sts.need_scan = active && ((is_close && cell_q != 8'd0) ||
		(is_closez && cell_q == 8'd0));
	assign sts.div_last  = dcnt_q == 3'd7;
	assign sts.scan_done = scan_done_q;
	assign sts.clr_last  = ({{(32-TW){1'b0}}, clr_q} == TAPE_CELLS - 1);

	// program memory port: write on append, read at pc or scan index
	logic [PW-1:0] prd_addr;
	always_comb begin
		if (cmd.scan_read) prd_addr = scan_q[PW-1:0] - 1'b1;
		else               prd_addr = pc_q[PW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.append && !(plen_q == LW'(PROGRAM_DEPTH))) prog_mem[plen_q[PW-1:0]] <= in_character;
		instr_q <= prog_mem[prd_addr];
	end

	// tape memory: one read port, one write port
	logic          twr_en;
	logic [TW-1:0] twr_addr;
	logic [7:0]    twr_data;
	logic [TW-1:0] trd_addr;
	logic [TW-1:0] nb_addr;
	logic          nb_oob;
	logic [7:0]    mul_res;
	logic [15:0]   mul_full;

	assign mul_full = cell_q * nb_c;
	assign mul_res  = mul_full[7:0];

	always_comb begin
		twr_en = 1'b0;
		twr_addr = ptr_q;
		twr_data = cell_q;
		if (cmd.clr_step) begin
			twr_en = 1'b1;
			twr_addr = clr_q;
			twr_data = 8'd0;
		end else if (cmd.div_done) begin
			twr_en = 1'b1;
			twr_data = quo_q;
		end else if (cmd.exec && active) begin
			priority case (1'b1)
				instr_q == CH_INC: begin twr_en = 1'b1; twr_data = cell_q + 8'd1; end
				instr_q == CH_DEC: begin twr_en = 1'b1; twr_data = cell_q - 8'd1; end
				instr_q == CH_IN || instr_q == CH_IN_I: begin
					twr_en = 1'b1; twr_data = val_q;
				end
				instr_q == CH_MUL: begin twr_en = 1'b1; twr_data = mul_res; end
				default: twr_en = 1'b0;
			endcase
		end
	end

	assign nb_oob  = ptr_last;
	assign nb_addr = ptr_q + 1'b1;
	// cycle after fetch reads the neighbour; otherwise the current cell, which
	// also keeps cell_value steady while a result waits
	always_comb begin
		if (fetch_d1_q) trd_addr = nb_addr;
		else            trd_addr = ptr_q;
	end

	always_ff @(posedge clk) begin
		if (twr_en) tape_mem[twr_addr] <= twr_data;
		trd_q <= tape_mem[trd_addr];
	end

	assign nb_c = nb_oob ? 8'd0 : trd_q;

	// fetch phase tracking: cycle after fetch holds cell, cycle after that neighbour
	logic fetch_d1_q, fetch_d2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			pc_q <= '0;
			ptr_q <= '0;
			stop_q <= ST_READY;
			clr_q <= '0;
			scan_q <= '0;
			depth_q <= '0;
			scan_done_q <= 1'b0;
			dcnt_q <= '0;
			fetch_d1_q <= 1'b0;
			fetch_d2_q <= 1'b0;
			full_q <= 1'b0;
			ovalid_q <= 1'b0;
			iused_q <= 1'b0;
		end else begin
			fetch_d1_q <= cmd.fetch;
			fetch_d2_q <= fetch_d1_q;
			if (cmd.load_in) begin
				ovalid_q <= 1'b0;
				iused_q <= 1'b0;
			end
			if (cmd.append) full_q <= (plen_q == LW'(PROGRAM_DEPTH));
			else if (cmd.load_in) full_q <= 1'b0;
			if (cmd.append && !(plen_q == LW'(PROGRAM_DEPTH))) plen_q <= plen_q + 1'b1;
			if (cmd.clear_prog) begin
				plen_q <= '0;
				pc_q <= '0;
				stop_q <= ST_READY;
			end
			if (cmd.rewind) begin
				pc_q <= '0;
				ptr_q <= '0;
				stop_q <= ST_READY;
				clr_q <= '0;
			end
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.exec && active) begin
				priority case (1'b1)
					instr_q == CH_RIGHT || instr_q == CH_RIGHT_N: begin
						pc_q <= pc_q + 1'b1;
						if (ptr_last) stop_q <= ST_RANGE;
						else ptr_q <= ptr_q + 1'b1;
					end
					instr_q == CH_LEFT || instr_q == CH_LEFT_P: begin
						pc_q <= pc_q + 1'b1;
						if (ptr_q == '0) stop_q <= ST_RANGE;
						else ptr_q <= ptr_q - 1'b1;
					end
					instr_q == CH_OUT || instr_q == CH_OUT_O: begin
						pc_q <= pc_q + 1'b1;
						ovalid_q <= 1'b1;
					end
					instr_q == CH_IN || instr_q == CH_IN_I: begin
						pc_q <= pc_q + 1'b1;
						iused_q <= 1'b1;
					end
					instr_q == CH_DIV: begin
						pc_q <= pc_q + 1'b1;
						stop_q <= ST_DIVZERO; // nonzero divisors go through the divider
					end
					default: pc_q <= pc_q + 1'b1;
				endcase
			end
			if (cmd.div_start) dcnt_q <= '0;
			if (cmd.div_step) dcnt_q <= dcnt_q + 1'b1;
			if (cmd.div_done) pc_q <= pc_q + 1'b1;
			if (cmd.scan_start) begin
				scan_q <= pc_q;
				depth_q <= LW'(1);
				scan_done_q <= 1'b0;
			end
			if (cmd.scan_read) begin
				if (scan_q == '0) begin
					stop_q <= ST_UNMATCH;
					scan_done_q <= 1'b1;
				end else begin
					scan_q <= scan_q - 1'b1;
				end
			end
			// after a run off the start there is no character to evaluate
			if (cmd.scan_eval && !scan_done_q) begin
				if (instr_q == CH_CLOSE || instr_q == CH_CLOSE_Z) begin
					depth_q <= depth_q + 1'b1;
				end else if (instr_q == CH_OPEN) begin
					depth_q <= depth_q - 1'b1;
					if (depth_q == LW'(1)) begin
						pc_q <= scan_q;
						scan_done_q <= 1'b1;
					end
				end
			end
		end
	end

	// cell and neighbour capture after fetch
	always_ff @(posedge clk) begin
		if (cmd.load_in) val_q <= in_value;
		if (fetch_d1_q) cell_q <= trd_q;
		if (fetch_d2_q) nb_q <= nb_c;
		if (cmd.exec) oval_q <= cell_q;
		if (cmd.load_in) oval_q <= 8'd0;
	end

	// restoring divider, one quotient bit per cycle
	logic [8:0] trial;
	assign trial = {rem_q, quo_q[7]} - {1'b0, nb_q};
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= cell_q;
			rem_q <= 8'd0;
		end else if (cmd.div_step) begin
			if (!trial[8]) begin
				rem_q <= trial[7:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= {rem_q[6:0], quo_q[7]};
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	// result word: cell read issued in the result cycle, captured next edge
	logic [2:0] stat_c;
	always_comb begin
		if (full_q) stat_c = ST_FULL;
		else if (stop_q != ST_READY) stat_c = stop_q;
		else if (pc_q >= plen_q) stat_c = ST_FINISHED;
		else stat_c = ST_READY;
	end

	logic [2:0]    stat_q;
	logic [LW-1:0] pcr_q;
	logic [TW-1:0] ptrr_q;
	always_ff @(posedge clk) begin
		if (cmd.result) begin
			stat_q <= stat_c;
			pcr_q <= pc_q;
			ptrr_q <= ptr_q;
		end
	end

	assign status          = stat_q;
	assign output_valid    = ovalid_q;
	assign output_value    = ovalid_q ? oval_q : 8'd0;
	assign input_used      = iused_q;
	assign program_counter = 11'(pcr_q);
	assign cell_pointer    = 7'(ptrr_q);
	assign cell_value      = trd_q;
endmodule

/* rtl/tape_machine_interpreter_step_unit.sv */
// Top level of the tape-language single-step interpreter.
//  channel | dir | handshake   | payload
//  in      | in  | valid/ready | operation, character, value
//  out     | out | valid/ready | status, output_valid, output_value, input_used,
//          |     |             | program_counter, cell_pointer, cell_value
// From the accepting cycle, append and clear go straight to the result state; a plain step
// passes fetch and execute first; a divide adds the serial divider, and a backward bracket
// scan reads the program back character by character. Rewind clears one cell a cycle.
// After reset a sweep zeroes every tape cell before ready rises.
// A result waits in its register; the next word is taken once it is gone or taken.
module tape_machine_interpreter_step_unit import tmis_pkg::*; #(
	parameter int unsigned PROGRAM_DEPTH = ProgramDepthDefault,
	parameter int unsigned TAPE_CELLS    = TapeCellsDefault
) (
	input logic    clk,
	input logic    arst_n,
	tmis_in_if.sink    in,
	tmis_out_if.source out
);
	tmis_cmd_t cmd;
	tmis_sts_t sts;

	tmis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready), .in_op(in.operation),
		.out_valid(out.valid), .out_ready(out.ready),
		.sts(sts), .cmd(cmd)
	);

	tmis_dp #(.PROGRAM_DEPTH(PROGRAM_DEPTH), .TAPE_CELLS(TAPE_CELLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_character(in.character), .in_value(in.value),
		.status(out.status), .output_valid(out.output_valid),
		.output_value(out.output_value), .input_used(out.input_used),
		.program_counter(out.program_counter), .cell_pointer(out.cell_pointer),
		.cell_value(out.cell_value)
	);
endmodule

/* sim/tb_tape_machine_interpreter_step_unit.sv */
// Testbench for the tape interpreter step unit: random programs checked by a scoreboard.
`timescale 1ns / 100ps

module tb_tape_machine_interpreter_step_unit;
	import tmis_pkg::*;

	localparam int unsigned PDEPTH = ProgramDepthDefault;
	localparam int unsigned TCELLS = TapeCellsDefault;
	localparam int unsigned WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]  status;
		logic        output_valid;
		logic [7:0]  output_value;
		logic        input_used;
		logic [10:0] program_counter;
		logic [6:0]  cell_pointer;
		logic [7:0]  cell_value;
	} step_word_t;

	class step_scoreboard;
		logic [7:0]  code_mem [PDEPTH];
		logic [7:0]  cells [TCELLS];
		int unsigned code_len;
		int unsigned pc;
		int unsigned ptr;
		logic [2:0]  stop;
		step_word_t  awaited [$];
		int unsigned mismatches;
		int unsigned words_checked;

		function new();
			code_len = 0;
			pc = 0;
			ptr = 0;
			stop = ST_READY;
			mismatches = 0;
			words_checked = 0;
			foreach (cells[i]) cells[i] = 8'd0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function logic [7:0] right_cell();
			if (ptr + 1 < TCELLS) return cells[ptr + 1];
			return 8'd0;
		endfunction

		function void scan_back();
			int unsigned depth;
			int unsigned k;
			logic [7:0]  c;
			depth = 1;
			k = pc;
			while (depth != 0) begin
				if (k == 0) begin
					stop = ST_UNMATCH;
					return;
				end
				k--;
				c = code_mem[k];
				if (c == CH_CLOSE || c == CH_CLOSE_Z) depth++;
				else if (c == CH_OPEN) depth--;
			end
			pc = k;
		endfunction

		function void exec_one(logic [7:0] val, ref step_word_t w);
			logic [7:0] c;
			logic [7:0] nb;
			c = code_mem[pc];
			case (c)
				CH_RIGHT, CH_RIGHT_N: begin
					pc++;
					if (ptr + 1 >= TCELLS) stop = ST_RANGE;
					else ptr++;
				end
				CH_LEFT, CH_LEFT_P: begin
					pc++;
					if (ptr == 0) stop = ST_RANGE;
					else ptr--;
				end
				CH_INC: begin
					pc++;
					cells[ptr] = cells[ptr] + 8'd1;
				end
				CH_DEC: begin
					pc++;
					cells[ptr] = cells[ptr] - 8'd1;
				end
				CH_OUT, CH_OUT_O: begin
					pc++;
					w.output_valid = 1'b1;
					w.output_value = cells[ptr];
				end
				CH_IN, CH_IN_I: begin
					pc++;
					w.input_used = 1'b1;
					cells[ptr] = val;
				end
				CH_CLOSE: begin
					if (cells[ptr] == 8'd0) pc++;
					else scan_back();
				end
				CH_CLOSE_Z: begin
					if (cells[ptr] != 8'd0) pc++;
					else scan_back();
				end
				CH_MUL: begin
					pc++;
					cells[ptr] = 8'((16'(cells[ptr]) * 16'(right_cell())));
				end
				CH_DIV: begin
					pc++;
					nb = right_cell();
					if (nb == 8'd0) stop = ST_DIVZERO;
					else cells[ptr] = cells[ptr] / nb;
				end
				default: pc++;
			endcase
		endfunction

		function void note(logic [1:0] op, logic [7:0] ch, logic [7:0] val);
			step_word_t w;
			bit         full;
			w = '0;
			full = 0;
			case (op)
				OP_APPEND: begin
					if (code_len >= PDEPTH) full = 1;
					else begin
						code_mem[code_len] = ch;
						code_len++;
					end
				end
				OP_STEP: begin
					if (stop == ST_READY && pc < code_len) exec_one(val, w);
				end
				OP_REWIND: begin
					foreach (cells[i]) cells[i] = 8'd0;
					pc = 0;
					ptr = 0;
					stop = ST_READY;
				end
				default: begin
					code_len = 0;
					pc = 0;
					stop = ST_READY;
				end
			endcase
			if (full) w.status = ST_FULL;
			else if (stop != ST_READY) w.status = stop;
			else w.status = (pc >= code_len) ? ST_FINISHED : ST_READY;
			w.program_counter = 11'(pc);
			w.cell_pointer = 7'(ptr);
			w.cell_value = cells[ptr];
			awaited.push_back(w);
		endfunction

		function void check(step_word_t got);
			step_word_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = awaited.pop_front();
			words_checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch (exp/act): st %0d/%0d ov %0d/%0d oval %0d/%0d iu %0d/%0d",
						want.status, got.status, want.output_valid, got.output_valid,
						want.output_value, got.output_value, want.input_used, got.input_used);
					$display("  pc %0d/%0d ptr %0d/%0d cell %0d/%0d",
						want.program_counter, got.program_counter, want.cell_pointer,
						got.cell_pointer, want.cell_value, got.cell_value);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	tmis_in_if  in_ch ();
	tmis_out_if out_ch ();

	tape_machine_interpreter_step_unit #(.PROGRAM_DEPTH(PDEPTH), .TAPE_CELLS(TCELLS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	step_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int unsigned words_sent;
	bit          finished_run;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver side: random stall, long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready = 1'b0;
			hold_left--;
		end else begin
			out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check({out_ch.status, out_ch.output_valid, out_ch.output_value,
				out_ch.input_used, out_ch.program_counter, out_ch.cell_pointer,
				out_ch.cell_value});
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT && !finished_run) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_word(logic [1:0] op, logic [7:0] ch, logic [7:0] val);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.operation = op;
		in_ch.character = ch;
		in_ch.value = val;
		do @(posedge clk); while (!in_ch.ready);
		sb.note(op, ch, val);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic load_text(string s);
		foreach (s[i]) send_word(OP_APPEND, s[i], 8'($urandom));
	endtask

	task automatic run_steps(int unsigned n);
		repeat (n) send_word(OP_STEP, 8'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] pick_instr();
		logic [7:0] set [16] = '{CH_RIGHT, CH_RIGHT_N, CH_LEFT, CH_LEFT_P, CH_INC, CH_DEC,
			CH_OUT, CH_OUT_O, CH_IN, CH_IN_I, CH_OPEN, CH_CLOSE, CH_CLOSE_Z, CH_MUL,
			CH_DIV, CH_INC};
		if ($urandom_range(9) == 0) return 8'($urandom);
		return set[$urandom_range(15)];
	endfunction

	task automatic set_idling(int unsigned phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
			default: begin send_idle_pct = 24; recv_stall_pct = 24; end
		endcase
	endtask

	initial begin
		int unsigned prog_no;
		int unsigned len;
		int unsigned i;
		sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_APPEND;
		in_ch.character = 8'd0;
		in_ch.value = 8'd0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		words_sent = 0;
		finished_run = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty program, edges, neighbour, divide by zero
		send_word(OP_STEP, 8'h00, 8'hFF);            // empty program
		load_text("<");
		run_steps(2);                                // left edge, then stuck
		send_word(OP_CLEAR, 8'h00, 8'h00);
		load_text("i*>-/.");
		send_word(OP_STEP, 8'h00, 8'hFF);
		run_steps(6);                                // right neighbour, div by zero
		send_word(OP_REWIND, 8'h00, 8'h00);
		load_text("+]");
		run_steps(4);
		drain();

		// a walk off the right end of the tape
		send_word(OP_CLEAR, 8'h00, 8'h00);
		send_word(OP_REWIND, 8'h00, 8'h00);
		load_text("+[>>>>>>>>+]");
		hold_left = 80;                              // fill the block with steps
		run_steps(200);
		drain();

		for (prog_no = 0; prog_no < 12; prog_no++) begin
			set_idling(prog_no / 3);
			send_word(OP_CLEAR, 8'($urandom), 8'($urandom));
			if ($urandom_range(3) != 0) send_word(OP_REWIND, 8'($urandom), 8'($urandom));
			len = $urandom_range(20, 3);
			repeat (len) send_word(OP_APPEND, pick_instr(), 8'($urandom));
			run_steps($urandom_range(30, 5));
			if ($urandom_range(9) == 0) send_word(OP_APPEND, pick_instr(), 8'($urandom));
			if (prog_no % 10 == 5) drain();
		end

		// fill the code store to its limit, then overflow it
		set_idling(3);
		send_word(OP_CLEAR, 8'h00, 8'h00);
		send_word(OP_REWIND, 8'h00, 8'h00);
		for (i = 0; i < PDEPTH; i++) begin
			if (i % 256 == 0) set_idling(i / 256);
			send_word(OP_APPEND, pick_instr(), 8'($urandom));
		end
		set_idling(3);
		send_word(OP_APPEND, 8'hFF, 8'h00);
		send_word(OP_APPEND, 8'h00, 8'h00);
		run_steps(30);
		send_word(OP_CLEAR, 8'h00, 8'h00);
		run_steps(2);

		drain();
		repeat (200) @(posedge clk);
		finished_run = 1;
		$display("sent %0d words, checked %0d results, %0d mismatches",
			words_sent, sb.words_checked, sb.mismatches);
		$display("covered random programs, tape edges, bracket scans, divide and store overflow");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/tmis_pkg.sv
rtl/tmis_if.sv
rtl/tmis_ctrl.sv
rtl/tmis_dp.sv
rtl/tape_machine_interpreter_step_unit.sv
sim/tb_tape_machine_interpreter_step_unit.sv
